>>> rtl/wpp_pkg.sv
// wpp_pkg: shared widths, request and register codes, and structs of the
// warped plasma pixel generator. depends on nothing; every other file imports it.
package wpp_pkg;

    // field widths
    localparam int REQ_W      = 2;
    localparam int PIX_W      = 9;
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 16;
    localparam int COLOR_W    = 16;
    localparam int SINE_W     = 8;
    localparam int SINE_DEPTH = 256;
    localparam int PAL_DEPTH  = 256;

    // signed pixel offset from the image centre
    localparam int COORD_W = 11;
    localparam int FRAC_BITS = 8;

    // configuration register widths
    localparam int COEF_W   = 10;
    localparam int SCALE_W  = 9;
    localparam int SHIFT_W  = 13;
    localparam int PHASE_W  = 10;
    localparam int PSHIFT_W = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int DEF_IMAGE_WIDTH  = 466;
    localparam int DEF_IMAGE_HEIGHT = 466;
    localparam int DEF_QUEUE_DEPTH  = 4;

    // request codes
    localparam logic [REQ_W-1:0] REQ_RENDER  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SINE    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PALETTE = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COS_COEF      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIN_COEF      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERP_SCALE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALONG_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_PHASE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PALETTE_SHIFT = 3'd7;

    // operation carried through the back pipeline
    typedef enum logic [1:0] {
        OP_RENDER,
        OP_SINE_WR,
        OP_PAL_WR
    } t_op;

    typedef struct packed {
        logic signed [COEF_W-1:0]  cos_coef;
        logic signed [COEF_W-1:0]  sin_coef;
        logic        [SCALE_W-1:0] perp_scale;
        logic        [SCALE_W-1:0] along_scale;
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic        [PHASE_W-1:0] frame_phase;
        logic        [PSHIFT_W-1:0] palette_shift;
    } t_cfg;

    typedef struct packed {
        t_op                        op;
        logic signed [COORD_W-1:0]  dx;
        logic signed [COORD_W-1:0]  dy;
        logic        [IDX_W-1:0]    idx;
        logic        [VAL_W-1:0]    val;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/wpp_if.sv
// wpp_if: valid/ready channel interfaces for pixel requests, colour results
// and configuration writes. depends on wpp_pkg.
interface wpp_pix_in_if import wpp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [IDX_W-1:0] table_index;
    logic [VAL_W-1:0] table_value;

    modport source (output valid, req_type, pixel_x, pixel_y, table_index, table_value,
                    input ready);
    modport sink (input valid, req_type, pixel_x, pixel_y, table_index, table_value,
                  output ready);
endinterface

interface wpp_pix_out_if import wpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink (input valid, pixel_color, output ready);
endinterface

interface wpp_cfg_if import wpp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/wpp_front.sv
// wpp_front: accepts request transactions, drops unused codes, centres the
// pixel coordinate and pushes work into the queue. depends on wpp_pkg, wpp_if.
module wpp_front import wpp_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT
) (
    wpp_pix_in_if.sink  i_pix,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_item       o_item
);

    localparam logic signed [COORD_W-1:0] CENTER_X = COORD_W'(IMAGE_WIDTH / 2);
    localparam logic signed [COORD_W-1:0] CENTER_Y = COORD_W'(IMAGE_HEIGHT / 2);

    logic w_keep;

    assign i_pix.ready = !i_q_status.full;

    always_comb begin
        o_item.op  = OP_RENDER;
        o_item.dx  = $signed({{(COORD_W-PIX_W){1'b0}}, i_pix.pixel_x}) - CENTER_X;
        o_item.dy  = $signed({{(COORD_W-PIX_W){1'b0}}, i_pix.pixel_y}) - CENTER_Y;
        o_item.idx = i_pix.table_index;
        o_item.val = i_pix.table_value;
        w_keep     = 1'b1;
        case (i_pix.req_type)
            REQ_RENDER:  o_item.op = OP_RENDER;
            REQ_SINE:    o_item.op = OP_SINE_WR;
            REQ_PALETTE: o_item.op = OP_PAL_WR;
            default:     w_keep = 1'b0;
        endcase
    end

    // unused code is consumed and never enters the queue
    assign o_push = i_pix.valid && i_pix.ready && w_keep;

endmodule

>>> rtl/wpp_queue.sv
// wpp_queue: small register fifo between front and back.
// depends on wpp_pkg.
module wpp_queue import wpp_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

endmodule

>>> rtl/wpp_back.sv
// wpp_back: nine-stage warp, sine and palette pipeline with the two tables.
// depends on wpp_pkg, wpp_if.
module wpp_back import wpp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  t_item          i_head,
    input  t_q_status      i_q_status,
    output logic           o_pop,
    wpp_pix_out_if.source  o_pix
);

    localparam int PROD1_W  = COORD_W + COEF_W;
    localparam int ROT_W    = PROD1_W + 1;
    localparam int SPROD_W  = ROT_W + SCALE_W + 1;
    localparam int SCL_W    = SPROD_W - FRAC_BITS;
    localparam int WRAP_W   = 16;
    localparam int LOW_W    = WRAP_W + FRAC_BITS;
    localparam int NUM_TAPS = 4;
    localparam int SINE_AW  = $clog2(SINE_DEPTH);
    localparam int PAL_AW   = $clog2(PAL_DEPTH);
    localparam int SUM_W    = SINE_W + 2;

    logic w_en;

    // stage valids and ops
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_s5_valid, r_s6_valid, r_s7_valid, r_s8_valid;
    logic r_out_valid;
    t_op  r_s1_op, r_s2_op, r_s3_op, r_s4_op, r_s5_op, r_s6_op, r_s7_op, r_s8_op;

    // table write payload carried with the item
    logic [IDX_W-1:0] r_s1_idx, r_s2_idx, r_s3_idx, r_s4_idx;
    logic [IDX_W-1:0] r_s5_idx, r_s6_idx, r_s7_idx, r_s8_idx;
    logic [VAL_W-1:0] r_s1_val, r_s2_val, r_s3_val, r_s4_val;
    logic [VAL_W-1:0] r_s5_val, r_s6_val, r_s7_val, r_s8_val;

    logic signed [PROD1_W-1:0] r_s1_pa, r_s1_pb, r_s1_pc, r_s1_pd;
    logic signed [ROT_W-1:0]   r_s2_rx, r_s2_ry;
    logic signed [SPROD_W-1:0] w_rx_prod, w_ry_prod;
    logic signed [SCL_W-1:0]   r_s3_rx, r_s3_ry;
    logic        [LOW_W-1:0]   r_s4_a, r_s4_b, r_s4_c, r_s4_d;
    logic        [LOW_W-1:0]   w_bx_sum, w_by_sum;
    logic        [WRAP_W-1:0]  r_s5_bx, r_s5_by;
    logic        [WRAP_W-1:0]  w_x3;
    logic        [SINE_AW-1:0] w_xx, w_yy, w_p0, w_p1, w_p2;
    logic        [SINE_AW-1:0] r_s6_addr [NUM_TAPS];
    logic        [SINE_W-1:0]  r_s7_sine [NUM_TAPS];
    logic        [SUM_W-1:0]   w_sum;
    logic        [PAL_AW-1:0]  r_s8_pidx;
    logic        [COLOR_W-1:0] r_out_color;
    logic        [COLOR_W-1:0] r_palette [PAL_DEPTH];

    // whole pipeline advances unless a result is held at the output
    assign w_en  = !r_out_valid || o_pix.ready;
    assign o_pop = w_en && !i_q_status.empty;

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_color = r_out_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_s7_valid  <= 1'b0;
            r_s8_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid  <= !i_q_status.empty;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_s7_valid  <= r_s6_valid;
            r_s8_valid  <= r_s7_valid;
            r_out_valid <= r_s8_valid && (r_s8_op == OP_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_op  <= i_head.op;
            r_s2_op  <= r_s1_op;
            r_s3_op  <= r_s2_op;
            r_s4_op  <= r_s3_op;
            r_s5_op  <= r_s4_op;
            r_s6_op  <= r_s5_op;
            r_s7_op  <= r_s6_op;
            r_s8_op  <= r_s7_op;
            r_s1_idx <= i_head.idx;
            r_s2_idx <= r_s1_idx;
            r_s3_idx <= r_s2_idx;
            r_s4_idx <= r_s3_idx;
            r_s5_idx <= r_s4_idx;
            r_s6_idx <= r_s5_idx;
            r_s7_idx <= r_s6_idx;
            r_s8_idx <= r_s7_idx;
            r_s1_val <= i_head.val;
            r_s2_val <= r_s1_val;
            r_s3_val <= r_s2_val;
            r_s4_val <= r_s3_val;
            r_s5_val <= r_s4_val;
            r_s6_val <= r_s5_val;
            r_s7_val <= r_s6_val;
            r_s8_val <= r_s7_val;
        end
    end

    // stage 1..3: rotate then scale; the 8.8 shift of the rotation cancels
    assign w_rx_prod = SPROD_W'(r_s2_rx) * SPROD_W'($signed({1'b0, i_cfg.perp_scale}));
    assign w_ry_prod = SPROD_W'(r_s2_ry) * SPROD_W'($signed({1'b0, i_cfg.along_scale}));

    // stage 5: only the low 16 bits of bx, by reach the wrapped coordinates
    assign w_bx_sum = r_s4_a + r_s4_b;
    assign w_by_sum = r_s4_d - r_s4_c;

    // stage 6: xx = bits 15:8 of 3*bx, yy = bits 15:8 of 2*by
    assign w_x3 = r_s5_bx + {r_s5_bx[WRAP_W-2:0], 1'b0};
    assign w_xx = w_x3[WRAP_W-1:FRAC_BITS];
    assign w_yy = r_s5_by[WRAP_W-2:FRAC_BITS-1];
    assign w_p0 = i_cfg.frame_phase[SINE_AW-1:0];
    assign w_p1 = i_cfg.frame_phase[SINE_AW:1];
    assign w_p2 = i_cfg.frame_phase[SINE_AW+1:2];

    assign w_sum = {2'b00, r_s7_sine[0]} + {2'b00, r_s7_sine[1]}
                 + {2'b00, r_s7_sine[2]} + {2'b00, r_s7_sine[3]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pa <= PROD1_W'(i_head.dx) * PROD1_W'(i_cfg.cos_coef);
            r_s1_pb <= PROD1_W'(i_head.dy) * PROD1_W'(i_cfg.sin_coef);
            r_s1_pc <= PROD1_W'(i_head.dx) * PROD1_W'(i_cfg.sin_coef);
            r_s1_pd <= PROD1_W'(i_head.dy) * PROD1_W'(i_cfg.cos_coef);
            r_s2_rx <= ROT_W'(r_s1_pa) - ROT_W'(r_s1_pb);
            r_s2_ry <= ROT_W'(r_s1_pc) + ROT_W'(r_s1_pd);
            r_s3_rx <= w_rx_prod[SPROD_W-1:FRAC_BITS];
            r_s3_ry <= w_ry_prod[SPROD_W-1:FRAC_BITS];
            r_s4_a  <= LOW_W'(r_s3_rx) * LOW_W'(i_cfg.cos_coef);
            r_s4_b  <= LOW_W'(r_s3_ry) * LOW_W'(i_cfg.sin_coef);
            r_s4_c  <= LOW_W'(r_s3_rx) * LOW_W'(i_cfg.sin_coef);
            r_s4_d  <= LOW_W'(r_s3_ry) * LOW_W'(i_cfg.cos_coef);
            r_s5_bx <= w_bx_sum[LOW_W-1:FRAC_BITS]
                     + {{(WRAP_W-SHIFT_W){i_cfg.shift_x[SHIFT_W-1]}}, i_cfg.shift_x};
            r_s5_by <= w_by_sum[LOW_W-1:FRAC_BITS]
                     + {{(WRAP_W-SHIFT_W){i_cfg.shift_y[SHIFT_W-1]}}, i_cfg.shift_y};
            r_s6_addr[0] <= w_xx + w_p0;
            r_s6_addr[1] <= w_yy + w_p1;
            r_s6_addr[2] <= w_xx + w_yy + w_p2;
            r_s6_addr[3] <= w_xx - w_yy - w_p1;
            r_s8_pidx <= w_sum[SUM_W-1:2] + i_cfg.palette_shift;
        end
    end

    // stage 7: four identical sine banks, one read port each; writes land in
    // pipeline order so later renders see them
    for (genvar k = 0; k < NUM_TAPS; k++) begin : g_sine
        logic [SINE_W-1:0] r_bank [SINE_DEPTH];

        always_ff @(posedge i_clk) begin
            if (w_en && r_s6_valid && (r_s6_op == OP_SINE_WR)) begin
                r_bank[r_s6_idx] <= r_s6_val[SINE_W-1:0];
            end
            if (w_en) begin
                r_s7_sine[k] <= r_bank[r_s6_addr[k]];
            end
        end
    end

    // stage 9: palette lookup straight into the output register
    always_ff @(posedge i_clk) begin
        if (w_en && r_s8_valid && (r_s8_op == OP_PAL_WR)) begin
            r_palette[r_s8_idx] <= r_s8_val;
        end
        if (w_en) begin
            r_out_color <= r_palette[r_s8_pidx];
        end
    end

endmodule

>>> rtl/warped_plasma_pixel_generator_top.sv
// warped_plasma_pixel_generator_top: configuration registers and the
// front / queue / back chain. depends on wpp_pkg, wpp_if, wpp_front, wpp_queue, wpp_back.
//
// one request transaction per clock while the queue has room: render requests return
// one colour word, sine and palette writes return nothing, and request code 3 is
// dropped at the input without using a queue slot. throughput is one transaction
// per cycle through a single nine-stage back pipeline that advances as a whole and
// holds only while its output register is full and not taken; the front keeps
// taking requests into a QUEUE_DEPTH-entry fifo during such a hold until it is full.
// the sine table sits in four banks (one read port each) read at stage seven, the
// colour table is read at stage nine; table writes travel the same pipeline, so
// any render behind a write sees the new entry. both tables power up undefined
// and must be written before a render reads them. configuration is always
// ready and should only change while the block is idle.
module warped_plasma_pixel_generator_top import wpp_pkg::*; #(
    parameter int IMAGE_WIDTH  = DEF_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEF_IMAGE_HEIGHT,
    parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    wpp_cfg_if.sink        i_cfg,
    wpp_pix_in_if.sink     i_pix,
    wpp_pix_out_if.source  o_pix
);

    t_cfg      r_cfg;
    logic      w_push;
    logic      w_pop;
    t_item     w_push_item;
    t_item     w_head;
    t_q_status w_q_status;

    // config writes never stall
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_coef      <= 10'sd256;
            r_cfg.sin_coef      <= '0;
            r_cfg.perp_scale    <= 9'd256;
            r_cfg.along_scale   <= 9'd256;
            r_cfg.shift_x       <= '0;
            r_cfg.shift_y       <= '0;
            r_cfg.frame_phase   <= '0;
            r_cfg.palette_shift <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_COS_COEF:      r_cfg.cos_coef      <= i_cfg.data[COEF_W-1:0];
                REG_SIN_COEF:      r_cfg.sin_coef      <= i_cfg.data[COEF_W-1:0];
                REG_PERP_SCALE:    r_cfg.perp_scale    <= i_cfg.data[SCALE_W-1:0];
                REG_ALONG_SCALE:   r_cfg.along_scale   <= i_cfg.data[SCALE_W-1:0];
                REG_SHIFT_X:       r_cfg.shift_x       <= i_cfg.data[SHIFT_W-1:0];
                REG_SHIFT_Y:       r_cfg.shift_y       <= i_cfg.data[SHIFT_W-1:0];
                REG_FRAME_PHASE:   r_cfg.frame_phase   <= i_cfg.data[PHASE_W-1:0];
                REG_PALETTE_SHIFT: r_cfg.palette_shift <= i_cfg.data[PSHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept, classify, centre
    wpp_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .i_pix      (i_pix),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // decoupling fifo
    wpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    // back: warp, sine sum, palette
    wpp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_head     (w_head),
        .i_q_status (w_q_status),
        .o_pop      (w_pop),
        .o_pix      (o_pix)
    );

`ifndef SYNTHESIS
    // reset empties the output register
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_pix.valid)
        else $error("output valid after reset");

    // fifo count stays consistent
    a_queue_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_status.full && w_q_status.empty))
        else $error("queue both full and empty");

    // back never pops an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_status.empty)
        else $error("pop from empty queue");

    // a full queue blocks new requests
    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> !w_push)
        else $error("push into full queue");
`endif

endmodule

>>> test/tb_warped_plasma_pixel_generator_top.sv
// tb_warped_plasma_pixel_generator_top: self-checking testbench for the warped plasma
// pixel generator, with an in-order color predictor and a checker on the result channel.
// depends on wpp_pkg, wpp_if and warped_plasma_pixel_generator_top.
module tb_warped_plasma_pixel_generator_top import wpp_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // request code the block drops without a result
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // nine-stage back pipeline plus the input queue, with margin
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 305;
    localparam int CFG_EVERY    = 120;
    localparam int MAX_REPORTS  = 40;
    localparam int CENTER_X     = DEF_IMAGE_WIDTH / 2;
    localparam int CENTER_Y     = DEF_IMAGE_HEIGHT / 2;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] val;
    } t_pix_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wpp_cfg_if     cfg_bus ();
    wpp_pix_in_if  req_bus ();
    wpp_pix_out_if color_bus ();

    warped_plasma_pixel_generator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (req_bus),
        .o_pix   (color_bus)
    );

    // predictor state: shadow tables and registers as the block should hold them
    logic [SINE_W-1:0]  sine_shadow    [SINE_DEPTH];
    logic [COLOR_W-1:0] palette_shadow [PAL_DEPTH];
    t_cfg               shadow_cfg;

    // colors owed by the block, oldest first
    logic [COLOR_W-1:0] pending_colors [$];
    logic [COLOR_W-1:0] want_color;

    // stall percentages per side, changed between phases
    int send_idle_pct;
    int recv_idle_pct;

    int err_count;
    int cycle_count;
    int n_renders;
    int n_sine_wr;
    int n_pal_wr;
    int n_dropped;
    int n_cfg_writes;
    int n_checked;

    // 10 ns clock, high and low halves
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung handshake or a missing result ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d colors still owed",
                     $time, cycle_count, pending_colors.size());
            $display("FAIL warped_plasma_pixel_generator_top");
            $finish;
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        color_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker: every accepted color against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && color_bus.valid && color_bus.ready) begin
            if (pending_colors.size() == 0) begin
                err_count <= err_count + 1;
                if (err_count < MAX_REPORTS)
                    $display("%0t: color transaction with none owed, actual %h",
                             $time, color_bus.pixel_color);
            end else begin
                want_color = pending_colors.pop_front();
                n_checked <= n_checked + 1;
                if (color_bus.pixel_color !== want_color) begin
                    err_count <= err_count + 1;
                    if (err_count < MAX_REPORTS)
                        $display("%0t: pixel_color mismatch, expected %h actual %h",
                                 $time, want_color, color_bus.pixel_color);
                end
            end
        end
    end

    // color of one pixel under the shadow registers and tables
    function automatic logic [COLOR_W-1:0] plasma_color(input logic [PIX_W-1:0] px,
                                                        input logic [PIX_W-1:0] py);
        longint cs, sn, perp, along, fx, fy, rx, ry, bx, by, wrapped;
        logic [7:0] xx, yy, p0, p1, p2, i0, i1, i2, i3, pal_idx;
        logic [9:0] sum;
        cs    = shadow_cfg.cos_coef;
        sn    = shadow_cfg.sin_coef;
        perp  = shadow_cfg.perp_scale;
        along = shadow_cfg.along_scale;
        fx = (longint'(px) - CENTER_X) * (longint'(1) << FRAC_BITS);
        fy = (longint'(py) - CENTER_Y) * (longint'(1) << FRAC_BITS);
        // rotate onto the warp axis, scale, rotate back; all shifts are floor divisions
        rx = (fx * cs - fy * sn) >>> FRAC_BITS;
        ry = (fx * sn + fy * cs) >>> FRAC_BITS;
        rx = (rx * perp) >>> FRAC_BITS;
        ry = (ry * along) >>> FRAC_BITS;
        bx = ((rx * cs + ry * sn) >>> FRAC_BITS) + longint'(shadow_cfg.shift_x);
        by = ((-rx * sn + ry * cs) >>> FRAC_BITS) + longint'(shadow_cfg.shift_y);
        // only the final 8-bit coordinates wrap
        wrapped = (bx * 3) >>> FRAC_BITS;
        xx = wrapped[7:0];
        wrapped = (by * 2) >>> FRAC_BITS;
        yy = wrapped[7:0];
        p0 = shadow_cfg.frame_phase[7:0];
        p1 = shadow_cfg.frame_phase[8:1];
        p2 = shadow_cfg.frame_phase[9:2];
        i0 = xx + p0;
        i1 = yy + p1;
        i2 = xx + yy + p2;
        i3 = xx - yy - p1;
        sum = 10'(sine_shadow[i0]) + 10'(sine_shadow[i1])
            + 10'(sine_shadow[i2]) + 10'(sine_shadow[i3]);
        pal_idx = sum[9:2] + shadow_cfg.palette_shift;
        return palette_shadow[pal_idx];
    endfunction

    // predictor update for one accepted request transaction
    task automatic predict_request(input t_pix_req r);
        case (r.req_type)
            REQ_RENDER: begin
                pending_colors.push_back(plasma_color(r.px, r.py));
                n_renders++;
            end
            REQ_SINE: begin
                sine_shadow[r.idx] = r.val[SINE_W-1:0];
                n_sine_wr++;
            end
            REQ_PALETTE: begin
                palette_shadow[r.idx] = r.val;
                n_pal_wr++;
            end
            default: n_dropped++;
        endcase
    endtask

    // one request transaction; valid stays high on return so back-to-back items stream
    task automatic send_request(input t_pix_req r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= r.req_type;
        req_bus.pixel_x     <= r.px;
        req_bus.pixel_y     <= r.py;
        req_bus.table_index <= r.idx;
        req_bus.table_value <= r.val;
        do @(posedge i_clk); while (!req_bus.ready);
        predict_request(r);
    endtask

    // stop sending and hold off until every owed color has come back
    task automatic wait_results();
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_colors.size() != 0);
    endtask

    // full idle: also lets trailing table writes leave the pipeline
    task automatic wait_idle();
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // write all eight registers, random junk above each register's width
    task automatic apply_cfg(input t_cfg c);
        logic [CFG_DATA_W-1:0] word;
        int r;
        for (r = 0; r < 8; r++) begin
            word = CFG_DATA_W'($urandom);
            case (CFG_IDX_W'(r))
                REG_COS_COEF:      word[COEF_W-1:0]   = c.cos_coef;
                REG_SIN_COEF:      word[COEF_W-1:0]   = c.sin_coef;
                REG_PERP_SCALE:    word[SCALE_W-1:0]  = c.perp_scale;
                REG_ALONG_SCALE:   word[SCALE_W-1:0]  = c.along_scale;
                REG_SHIFT_X:       word[SHIFT_W-1:0]  = c.shift_x;
                REG_SHIFT_Y:       word[SHIFT_W-1:0]  = c.shift_y;
                REG_FRAME_PHASE:   word[PHASE_W-1:0]  = c.frame_phase;
                REG_PALETTE_SHIFT: word[PSHIFT_W-1:0] = c.palette_shift;
                default: ;
            endcase
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= CFG_IDX_W'(r);
            cfg_bus.data  <= word;
            do @(posedge i_clk); while (!cfg_bus.ready);
            n_cfg_writes++;
        end
        cfg_bus.valid <= 1'b0;
        shadow_cfg = c;
    endtask

    function automatic t_pix_req make_req(input logic [REQ_W-1:0] kind,
                                          input int px, input int py);
        t_pix_req r;
        r.req_type = kind;
        r.px  = PIX_W'(px);
        r.py  = PIX_W'(py);
        r.idx = IDX_W'($urandom);
        r.val = VAL_W'($urandom);
        return r;
    endfunction

    // mostly renders over the whole 9-bit coordinate range, some table rewrites and dropped codes
    function automatic t_pix_req rand_req();
        int pick;
        t_pix_req r;
        pick = $urandom_range(99);
        r = make_req(REQ_RENDER, $urandom, $urandom);
        if (pick >= 95)
            r.req_type = REQ_UNUSED;
        else if (pick >= 88)
            r.req_type = REQ_PALETTE;
        else if (pick >= 80)
            r.req_type = REQ_SINE;
        return r;
    endfunction

    // coefficients usually in the rotation range, sometimes any bit pattern
    function automatic t_cfg rand_cfg();
        t_cfg c;
        c.cos_coef      = ($urandom_range(3) == 0) ? COEF_W'($urandom)
                                                   : COEF_W'($urandom_range(512) - 256);
        c.sin_coef      = ($urandom_range(3) == 0) ? COEF_W'($urandom)
                                                   : COEF_W'($urandom_range(512) - 256);
        c.perp_scale    = SCALE_W'($urandom);
        c.along_scale   = SCALE_W'($urandom);
        c.shift_x       = SHIFT_W'($urandom);
        c.shift_y       = SHIFT_W'($urandom);
        c.frame_phase   = PHASE_W'($urandom);
        c.palette_shift = PSHIFT_W'($urandom);
        return c;
    endfunction

    // fill both tables so that no render can read an unwritten entry
    task automatic test_table_load();
        int i;
        t_pix_req r;
        for (i = 0; i < SINE_DEPTH; i++) begin
            r = make_req(REQ_SINE, $urandom, $urandom);
            r.idx = IDX_W'(i);
            send_request(r);
        end
        for (i = 0; i < PAL_DEPTH; i++) begin
            r = make_req(REQ_PALETTE, $urandom, $urandom);
            r.idx = IDX_W'(i);
            send_request(r);
        end
    endtask

    // reset registers: image corners, center, pixels beyond the image, dropped code, table writes
    task automatic test_reset_config();
        t_pix_req r;
        send_request(make_req(REQ_RENDER, 0, 0));
        send_request(make_req(REQ_RENDER, DEF_IMAGE_WIDTH - 1, DEF_IMAGE_HEIGHT - 1));
        send_request(make_req(REQ_RENDER, DEF_IMAGE_WIDTH - 1, 0));
        send_request(make_req(REQ_RENDER, 0, DEF_IMAGE_HEIGHT - 1));
        send_request(make_req(REQ_RENDER, CENTER_X, CENTER_Y));
        // outside the image, computed the same way
        send_request(make_req(REQ_RENDER, DEF_IMAGE_WIDTH, DEF_IMAGE_HEIGHT));
        send_request(make_req(REQ_RENDER, 511, 511));
        // unused code carries a render-looking payload and must vanish
        send_request(make_req(REQ_UNUSED, 0, 0));
        // table writes with all ones, render right behind them
        r = make_req(REQ_SINE, 0, 0);
        r.idx = '1;
        r.val = '1;
        send_request(r);
        r = make_req(REQ_PALETTE, 0, 0);
        r.idx = '0;
        r.val = '1;
        send_request(r);
        send_request(make_req(REQ_RENDER, CENTER_X, CENTER_Y));
    endtask

    // register extremes at both ends, and a quarter-turn warp
    task automatic test_cfg_extremes();
        t_cfg c;
        wait_idle();
        c = '{cos_coef: 10'sd511, sin_coef: -10'sd512, perp_scale: '1, along_scale: '1,
              shift_x: 13'sd4095, shift_y: -13'sd4096, frame_phase: '1, palette_shift: '1};
        apply_cfg(c);
        send_request(make_req(REQ_RENDER, 0, 0));
        send_request(make_req(REQ_RENDER, 511, 511));
        send_request(make_req(REQ_RENDER, 0, 511));
        send_request(make_req(REQ_RENDER, 511, 0));
        send_request(make_req(REQ_RENDER, CENTER_X, CENTER_Y));
        wait_idle();
        c = '{cos_coef: -10'sd512, sin_coef: 10'sd511, perp_scale: '0, along_scale: '0,
              shift_x: -13'sd4096, shift_y: 13'sd4095, frame_phase: '0, palette_shift: '0};
        apply_cfg(c);
        send_request(make_req(REQ_RENDER, 0, 0));
        send_request(make_req(REQ_RENDER, 511, 511));
        send_request(make_req(REQ_RENDER, 100, 400));
        wait_idle();
        c = '{cos_coef: 10'sd0, sin_coef: 10'sd256, perp_scale: 9'd128, along_scale: 9'd384,
              shift_x: 13'sd300, shift_y: -13'sd700, frame_phase: 10'd515, palette_shift: 8'd77};
        apply_cfg(c);
        send_request(make_req(REQ_RENDER, 10, 300));
        send_request(make_req(REQ_RENDER, 465, 7));
        send_request(make_req(REQ_RENDER, 250, 250));
    endtask

    // random traffic under one idling pattern, new registers every so often
    task automatic test_random_phase(input int src_idle, input int snk_idle);
        int i;
        wait_idle();
        send_idle_pct = src_idle;
        recv_idle_pct = snk_idle;
        apply_cfg(rand_cfg());
        for (i = 0; i < PHASE_ITEMS; i++) begin
            if (i != 0 && i % CFG_EVERY == 0) begin
                wait_idle();
                apply_cfg(rand_cfg());
            end else if (i == PHASE_ITEMS / 2 || $urandom_range(149) == 0) begin
                // sender holds off until every owed color has come back
                wait_results();
            end
            send_request(rand_req());
        end
    endtask

    initial begin
        // every input known from time zero
        i_rst_n             = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = REQ_RENDER;
        req_bus.pixel_x     = '0;
        req_bus.pixel_y     = '0;
        req_bus.table_index = '0;
        req_bus.table_value = '0;
        color_bus.ready     = 1'b0;
        send_idle_pct       = 33;
        recv_idle_pct       = 68;
        // register values the block comes out of reset with
        shadow_cfg = '{cos_coef: 10'sd256, sin_coef: 10'sd0, perp_scale: 9'd256,
                       along_scale: 9'd256, shift_x: '0, shift_y: '0, frame_phase: '0,
                       palette_shift: '0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_reset_config();
        test_cfg_extremes();
        test_random_phase(33, 68);
        test_random_phase(68, 33);
        test_random_phase(0, 0);
        wait_idle();

        $display("run covered %0d renders, %0d sine and %0d palette writes, %0d dropped codes",
                 n_renders, n_sine_wr, n_pal_wr, n_dropped);
        $display("%0d colors compared over %0d register writes, %0d errors",
                 n_checked, n_cfg_writes, err_count);
        if (err_count == 0) begin
            $display("PASS warped_plasma_pixel_generator_top");
        end else begin
            $display("FAIL warped_plasma_pixel_generator_top");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/wpp_pkg.sv
rtl/wpp_if.sv
rtl/wpp_front.sv
rtl/wpp_queue.sv
rtl/wpp_back.sv
rtl/warped_plasma_pixel_generator_top.sv
test/tb_warped_plasma_pixel_generator_top.sv
